// ----- design/fkc_pkg.sv -----
// Package for the sequence k-mer cycle counter.
// Holds the widths, character and code constants, the item struct and helper functions.
// Used by both interfaces and every module of the block.
package fkc_pkg;

    localparam int MAX_K      = 32;
    localparam int COUNT_BITS = 48;
    localparam int OUT_BITS   = 48;
    localparam int K_BITS     = 6;
    localparam int OV_BITS    = $clog2(MAX_K);
    localparam int CODE_BITS  = 2 * (MAX_K - 1);
    localparam int IDX_BITS   = 1;
    localparam int CFG_BITS   = K_BITS;

    // Configuration register indexes.
    localparam logic [IDX_BITS-1:0] CFG_MODE = 1'b0;
    localparam logic [IDX_BITS-1:0] CFG_KMER = 1'b1;

    // Counting modes.
    localparam logic MODE_CHARS = 1'b0;
    localparam logic MODE_KMER  = 1'b1;

    // Item opcodes.
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_HEADER  = 8'h3E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_item;

    // Returns {is_base, code} with A=0, C=1, G=2, T=3 in either case.
    function automatic logic [2:0] base_code(input logic [7:0] c);
        logic [2:0] res;
        case (c)
            "A", "a": res = 3'b100;
            "C", "c": res = 3'b101;
            "G", "g": res = 3'b110;
            "T", "t": res = 3'b111;
            default:  res = 3'b000;
        endcase
        return res;
    endfunction

    function automatic logic is_target(input logic [7:0] c);
        logic [2:0] bc;
        bc = base_code(c);
        return bc[2] || (c == CH_LPAREN) || (c == CH_RPAREN);
    endfunction

    // Zero acts as one and values above MAX_K act as MAX_K.
    function automatic logic [K_BITS-1:0] eff_k(input logic [K_BITS-1:0] k);
        logic [K_BITS-1:0] res;
        if (k == '0) begin
            res = K_BITS'(1);
        end else if (k > K_BITS'(MAX_K)) begin
            res = K_BITS'(MAX_K);
        end else begin
            res = k;
        end
        return res;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

endpackage

// ----- design/fkc_in_if.sv -----
// Input channel of the sequence k-mer cycle counter: valid, ready and the item payload.
// Depends on fkc_pkg.
interface fkc_in_if import fkc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

// ----- design/fkc_out_if.sv -----
// Result channel of the sequence k-mer cycle counter: valid, ready and the result payload.
// Depends on fkc_pkg.
interface fkc_out_if import fkc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] base_count;
    logic [OUT_BITS-1:0] cycle_count;
    logic                finished;

    modport source (output valid, output base_count, output cycle_count, output finished,
                    input ready);
    modport sink   (input valid, input base_count, input cycle_count, input finished,
                    output ready);
endinterface

// ----- design/fasta_kmer_cycle_counter_core.sv -----
// Top level of the sequence byte-stream base and implicit-cycle counter.
// Depends on fkc_pkg, fkc_in_if, fkc_out_if, fkc_in_stage and fkc_count_unit.
//
// The block takes one byte of a sequence text stream per item and answers every item with
// one result carrying the running base total, the running implicit cycle total and a flag
// that marks the answer to a finish item. Lines that open with '>' are headers and are
// skipped through their newline. In mode 0 each A, C, G, T, '(' or ')' in either case adds
// one to the base total. In mode 1 runs of bases are tracked as 2-bit codes; when a run
// ends, its length is added, unless its first k-1 bases equal its last k-1 bases, in which
// case the length minus k-1 is added and one cycle is counted. A finish item flushes an open
// run (in mode 1), reports the totals and clears all stream state; the configuration stays.
// Both totals saturate. The block sustains one item per clock while results are taken:
// every item is registered at the input, its whole update (a 62-bit code compare, a
// 48-bit subtract and compare, and saturating adds) is done combinationally from that
// register, and the answer is loaded into an output register that drives the result port.
// The result register reloads in the same cycle its result is taken, so items flow back to
// back; while a result waits, the input register still accepts one more item.
// Configuration is written through a simple write port: index 0 is the mode, index 1 the
// k-mer length (0 acts as 1 and values above 32 act as 32). Write it only while idle.
module fasta_kmer_cycle_counter_core
    import fkc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    fkc_in_if.sink              i_item,
    fkc_out_if.source           o_result,
    input  logic                i_cfg_we,
    input  logic [IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_wdata
);

    logic              r_mode;
    logic [K_BITS-1:0] r_kmer_length;

    logic  stage_valid;
    t_item stage_item;
    logic  stage_take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_CHARS;
            r_kmer_length <= K_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE: r_mode        <= i_cfg_wdata[0];
                CFG_KMER: r_kmer_length <= i_cfg_wdata[K_BITS-1:0];
                default:  r_mode        <= r_mode;
            endcase
        end
    end

    // Input register: holds one item until the counting stage takes it.
    fkc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    // Counting stage: updates the stream state and loads the result register.
    fkc_count_unit u_count_unit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (stage_valid),
        .i_item        (stage_item),
        .i_mode        (r_mode),
        .i_kmer_length (r_kmer_length),
        .o_take        (stage_take),
        .o_result      (o_result)
    );

endmodule

// ----- design/fkc_in_stage.sv -----
// Input register of the sequence k-mer cycle counter.
// Depends on fkc_pkg and fkc_in_if.
module fkc_in_stage
    import fkc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    fkc_in_if.sink      i_item,
    input  logic        i_take,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;

    // The register can load when empty or when its item moves on this cycle.
    assign i_item.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_item.opcode    <= i_item.opcode;
            r_item.data_byte <= i_item.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- design/fkc_count_unit.sv -----
// Parser state, run tracking, totals and result register of the k-mer cycle counter.
// Depends on fkc_pkg and fkc_out_if.
module fkc_count_unit
    import fkc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item             i_item,
    input  logic              i_mode,
    input  logic [K_BITS-1:0] i_kmer_length,
    output logic              o_take,
    fkc_out_if.source         o_result
);

    logic                  r_in_header, n_in_header;
    logic                  r_line_start, n_line_start;
    logic [COUNT_BITS-1:0] r_run, n_run;
    logic [CODE_BITS-1:0]  r_prefix, n_prefix;
    logic [CODE_BITS-1:0]  r_suffix, n_suffix;
    logic [COUNT_BITS-1:0] r_bases, n_bases;
    logic [COUNT_BITS-1:0] r_cycles, n_cycles;

    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_base;
    logic [OUT_BITS-1:0] r_out_cycle;
    logic                r_out_fin;

    logic [K_BITS-1:0]     k_eff;
    logic [OV_BITS-1:0]    ov;
    logic [CODE_BITS-1:0]  mask;
    logic [2:0]            bc;
    logic                  close_cycle;
    logic [COUNT_BITS-1:0] close_amt;
    logic [COUNT_BITS-1:0] closed_bases;
    logic [COUNT_BITS-1:0] closed_cycles;
    logic                  hdr;
    logic [CODE_BITS-1:0]  new_prefix;

    assign o_take = i_valid && (!r_out_valid || o_result.ready);

    assign k_eff = eff_k(i_kmer_length);
    assign ov    = OV_BITS'(k_eff - K_BITS'(1));
    assign mask  = ~({CODE_BITS{1'b1}} << {ov, 1'b0});
    assign bc    = base_code(i_item.data_byte);

    // Closing a run: a run whose first and last k-1 bases match counts as one cycle.
    assign close_cycle   = (r_run != '0) && (r_run >= COUNT_BITS'(ov)) && (r_prefix == r_suffix);
    assign close_amt     = close_cycle ? (r_run - COUNT_BITS'(ov)) : r_run;
    assign closed_bases  = sat_add(r_bases, close_amt);
    assign closed_cycles = sat_add(r_cycles, COUNT_BITS'(close_cycle));

    assign hdr        = r_line_start ? (i_item.data_byte == CH_HEADER) : r_in_header;
    assign new_prefix = ((r_prefix << 2) | CODE_BITS'(bc[1:0])) & mask;

    always_comb begin
        n_in_header  = r_in_header;
        n_line_start = r_line_start;
        n_run        = r_run;
        n_prefix     = r_prefix;
        n_suffix     = r_suffix;
        n_bases      = r_bases;
        n_cycles     = r_cycles;
        if (i_item.opcode == OP_FINISH) begin
            if (i_mode == MODE_KMER) begin
                n_bases  = closed_bases;
                n_cycles = closed_cycles;
            end
        end else begin
            n_in_header  = hdr;
            n_line_start = 1'b0;
            if (hdr) begin
                n_line_start = (i_item.data_byte == CH_NEWLINE);
            end else if (i_mode == MODE_KMER) begin
                if (!bc[2]) begin
                    n_bases      = closed_bases;
                    n_cycles     = closed_cycles;
                    n_run        = '0;
                    n_prefix     = '0;
                    n_suffix     = '0;
                    n_line_start = (i_item.data_byte == CH_NEWLINE);
                end else begin
                    n_run = sat_add(r_run, COUNT_BITS'(1));
                    if (r_run < COUNT_BITS'(ov)) begin
                        n_prefix = new_prefix;
                        n_suffix = new_prefix;
                    end else begin
                        n_suffix = ((r_suffix << 2) | CODE_BITS'(bc[1:0])) & mask;
                    end
                end
            end else begin
                if (i_item.data_byte == CH_NEWLINE) begin
                    n_line_start = 1'b1;
                end else if (is_target(i_item.data_byte)) begin
                    n_bases = sat_add(r_bases, COUNT_BITS'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header  <= 1'b0;
            r_line_start <= 1'b1;
            r_run        <= '0;
            r_prefix     <= '0;
            r_suffix     <= '0;
            r_bases      <= '0;
            r_cycles     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_take) begin
                if (i_item.opcode == OP_FINISH) begin
                    r_in_header  <= 1'b0;
                    r_line_start <= 1'b1;
                    r_run        <= '0;
                    r_prefix     <= '0;
                    r_suffix     <= '0;
                    r_bases      <= '0;
                    r_cycles     <= '0;
                end else begin
                    r_in_header  <= n_in_header;
                    r_line_start <= n_line_start;
                    r_run        <= n_run;
                    r_prefix     <= n_prefix;
                    r_suffix     <= n_suffix;
                    r_bases      <= n_bases;
                    r_cycles     <= n_cycles;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_base  <= n_bases[OUT_BITS-1:0];
            r_out_cycle <= n_cycles[OUT_BITS-1:0];
            r_out_fin   <= (i_item.opcode == OP_FINISH);
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.base_count  = r_out_base;
    assign o_result.cycle_count = r_out_cycle;
    assign o_result.finished    = r_out_fin;

endmodule

// ----- bench/tb_fasta_kmer_cycle_counter_core.sv -----
// Self-checking testbench for fasta_kmer_cycle_counter_core.
// Sends sequence-text items with random sender gaps and receiver stalls and checks each
// result against a predictor kept in step with every accepted item.
// Depends on fkc_pkg, fkc_in_if, fkc_out_if.
module tb_fasta_kmer_cycle_counter_core
    import fkc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // A phase ends plainly, with a base run left open, or with a finish item.
    localparam int END_PLAIN  = 0;
    localparam int END_OPEN   = 1;
    localparam int END_FINISH = 2;

    // Cycles without any accepted item or result before the run is declared hung.
    localparam int HANG_LIMIT = 2000;

    typedef struct packed {
        logic [OUT_BITS-1:0] bases;
        logic [OUT_BITS-1:0] cycles;
        logic                fin;
    } t_tally;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Everything the bench drives starts at a known value.
    logic                drv_valid = 1'b0;
    logic                drv_op    = OP_DATA;
    logic [7:0]          drv_byte  = 8'h00;
    logic                rsp_ready = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [IDX_BITS-1:0] cfg_idx   = CFG_MODE;
    logic [CFG_BITS-1:0] cfg_data  = '0;

    fkc_in_if  item_bus ();
    fkc_out_if result_bus ();

    assign item_bus.valid     = drv_valid;
    assign item_bus.opcode    = drv_op;
    assign item_bus.data_byte = drv_byte;
    assign result_bus.ready   = rsp_ready;

    fasta_kmer_cycle_counter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_bus),
        .o_result    (result_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_idx),
        .i_cfg_wdata (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Items waiting to be sent, and the totals the block must report, oldest first.
    t_item  pending[$];
    t_tally tally_q[$];

    // Bench copy of the configuration registers, at their reset values.
    logic               p_mode = MODE_CHARS;
    logic [K_BITS-1:0]  p_k    = K_BITS'(1);

    // Bench copy of the stream state.
    logic                  hdr_line   = 1'b0;
    logic                  line_start = 1'b1;
    logic [COUNT_BITS-1:0] run_len    = '0;
    logic [CODE_BITS-1:0]  head_code  = '0;
    logic [CODE_BITS-1:0]  tail_code  = '0;
    logic [COUNT_BITS-1:0] tot_bases  = '0;
    logic [COUNT_BITS-1:0] tot_cycles = '0;

    // Idling knobs, changed only between phases.
    int unsigned gap_max   = 0;
    int unsigned stall_max = 0;

    int unsigned n_generated   = 0;
    int unsigned n_accepted    = 0;
    int unsigned n_finishes    = 0;
    int unsigned n_checked     = 0;
    int unsigned n_cycles_pred = 0;
    int unsigned n_settings    = 0;
    int unsigned n_errors      = 0;

    //------------------------------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------------------------------

    function automatic logic [COUNT_BITS-1:0] sum_clamped(input logic [COUNT_BITS-1:0] a,
                                                          input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[COUNT_BITS]) begin
            return {COUNT_BITS{1'b1}};
        end
        return s[COUNT_BITS-1:0];
    endfunction

    // The register is read on every item; zero behaves as one and anything past MAX_K as MAX_K.
    function automatic int unsigned k_in_use(input logic [K_BITS-1:0] k);
        if (k == '0) begin
            return 1;
        end
        if (int'(k) > MAX_K) begin
            return MAX_K;
        end
        return int'(k);
    endfunction

    // Closing a run adds its length, or its length less the overlap plus one cycle when the
    // leading and trailing k-1 bases agree. With k of one the overlap is empty and always agrees.
    function automatic void close_run(input int unsigned kk);
        logic [COUNT_BITS-1:0] ov;
        ov = COUNT_BITS'(kk - 1);
        if (run_len != '0) begin
            if (run_len >= ov && head_code == tail_code) begin
                tot_bases  = sum_clamped(tot_bases, run_len - ov);
                tot_cycles = sum_clamped(tot_cycles, COUNT_BITS'(1));
                n_cycles_pred++;
            end else begin
                tot_bases = sum_clamped(tot_bases, run_len);
            end
        end
        run_len   = '0;
        head_code = '0;
        tail_code = '0;
    endfunction

    // Advances the bench state by one accepted item and queues the totals it must produce.
    function automatic void step_counter(input logic op, input logic [7:0] c);
        int unsigned kk;
        logic [63:0] mask;
        logic [1:0]  code;
        logic        is_base;
        t_tally      t;
        kk = k_in_use(p_k);
        if (op == OP_FINISH) begin
            // An open run only counts when the finish arrives in k-mer mode.
            if (p_mode == MODE_KMER) begin
                close_run(kk);
            end
            t.bases  = tot_bases[OUT_BITS-1:0];
            t.cycles = tot_cycles[OUT_BITS-1:0];
            t.fin    = 1'b1;
            hdr_line   = 1'b0;
            line_start = 1'b1;
            run_len    = '0;
            head_code  = '0;
            tail_code  = '0;
            tot_bases  = '0;
            tot_cycles = '0;
        end else begin
            if (line_start) begin
                hdr_line   = (c == CH_HEADER);
                line_start = 1'b0;
            end
            // Folding bit 5 lower-cases letters, so each base matches in either case.
            is_base = 1'b1;
            case (c | 8'h20)
                "a":     code = 2'd0;
                "c":     code = 2'd1;
                "g":     code = 2'd2;
                "t":     code = 2'd3;
                default: begin
                    code    = 2'd0;
                    is_base = 1'b0;
                end
            endcase
            if (hdr_line) begin
                if (c == CH_NEWLINE) begin
                    line_start = 1'b1;
                end
            end else if (p_mode == MODE_KMER) begin
                if (!is_base) begin
                    close_run(kk);
                    if (c == CH_NEWLINE) begin
                        line_start = 1'b1;
                    end
                end else begin
                    mask    = (64'd1 << (2 * (kk - 1))) - 64'd1;
                    run_len = sum_clamped(run_len, COUNT_BITS'(1));
                    if (run_len < COUNT_BITS'(kk)) begin
                        head_code = ((head_code << 2) | CODE_BITS'(code)) & mask[CODE_BITS-1:0];
                        tail_code = head_code;
                    end else begin
                        tail_code = ((tail_code << 2) | CODE_BITS'(code)) & mask[CODE_BITS-1:0];
                    end
                end
            end else begin
                if (c == CH_NEWLINE) begin
                    line_start = 1'b1;
                end else if (is_base || c == CH_LPAREN || c == CH_RPAREN) begin
                    tot_bases = sum_clamped(tot_bases, COUNT_BITS'(1));
                end
            end
            t.bases  = tot_bases[OUT_BITS-1:0];
            t.cycles = tot_cycles[OUT_BITS-1:0];
            t.fin    = 1'b0;
        end
        tally_q.push_back(t);
    endfunction

    //------------------------------------------------------------------------------------------
    // Driver: sends pending items in bursts of random length separated by random gaps. The
    // item on the bus is held until it is taken; the prediction is made at the edge where it
    // is accepted, so it always sees the configuration the block sees.
    //------------------------------------------------------------------------------------------

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    t_item       next_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (drv_valid && item_bus.ready) begin
                step_counter(drv_op, drv_byte);
                n_accepted++;
                if (drv_op == OP_FINISH) begin
                    n_finishes++;
                end
            end
            if (!drv_valid || item_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    drv_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    next_item = pending.pop_front();
                    drv_valid <= 1'b1;
                    drv_op    <= next_item.opcode;
                    drv_byte  <= next_item.data_byte;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------------------------------
    // Monitor: the receiver holds ready high or low for random stretches, and every result it
    // takes is compared field by field with the oldest queued totals.
    //------------------------------------------------------------------------------------------

    int unsigned stall_left = 0;
    t_tally      want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ready  <= 1'b0;
            stall_left = 0;
        end else begin
            if (result_bus.valid && rsp_ready) begin
                n_checked++;
                if (tally_q.size() == 0) begin
                    $display("%0t: result with no item outstanding: base_count %0d cycle_count %0d",
                             $time, result_bus.base_count, result_bus.cycle_count);
                    n_errors++;
                end else begin
                    want = tally_q.pop_front();
                    if (result_bus.base_count !== want.bases) begin
                        $display("%0t: base_count mismatch: expected %0d, actual %0d",
                                 $time, want.bases, result_bus.base_count);
                        n_errors++;
                    end
                    if (result_bus.cycle_count !== want.cycles) begin
                        $display("%0t: cycle_count mismatch: expected %0d, actual %0d",
                                 $time, want.cycles, result_bus.cycle_count);
                        n_errors++;
                    end
                    if (result_bus.finished !== want.fin) begin
                        $display("%0t: finished mismatch: expected %0b, actual %0b",
                                 $time, want.fin, result_bus.finished);
                        n_errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (stall_max == 0) begin
                rsp_ready <= 1'b1;
            end else begin
                rsp_ready  <= ($urandom_range(0, 2) != 0);
                stall_left = $urandom_range(0, stall_max);
            end
        end
    end

    //------------------------------------------------------------------------------------------
    // Watchdog: a long stretch with nothing moving on either channel means the block hung.
    //------------------------------------------------------------------------------------------

    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((drv_valid && item_bus.ready) || (result_bus.valid && rsp_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results still outstanding",
                         $time, HANG_LIMIT, tally_q.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------------------------------

    function automatic void push_byte(input logic [7:0] b);
        t_item it;
        it.opcode    = OP_DATA;
        it.data_byte = b;
        pending.push_back(it);
        n_generated++;
    endfunction

    // The data byte of a finish is ignored by the block, so it is left random.
    function automatic void push_finish();
        t_item it;
        it.opcode    = OP_FINISH;
        it.data_byte = 8'($urandom_range(0, 255));
        pending.push_back(it);
        n_generated++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endfunction

    function automatic logic [7:0] base_char(input int unsigned code);
        logic [7:0] ch;
        case (code)
            0:       ch = "A";
            1:       ch = "C";
            2:       ch = "G";
            default: ch = "T";
        endcase
        if ($urandom_range(0, 1) != 0) begin
            ch = ch | 8'h20;
        end
        return ch;
    endfunction

    // Byte that usually ends a run; the odd random byte may extend it instead.
    function automatic logic [7:0] pick_break();
        case ($urandom_range(0, 5))
            0, 1:    return CH_NEWLINE;
            2:       return "N";
            3:       return 8'h0D;
            4:       return ",";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void push_header();
        logic [7:0] b;
        push_byte(CH_HEADER);
        repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            push_byte((b == CH_NEWLINE) ? "x" : b);
        end
        push_byte(CH_NEWLINE);
    endfunction

    // A run of bases shaped so that many of them close as cycles for the given k.
    function automatic void push_run(input int unsigned kk);
        int unsigned ov;
        int unsigned len;
        int unsigned code;
        int unsigned motif[$];
        ov = kk - 1;
        case ($urandom_range(0, 3))
            0: begin
                len = $urandom_range(1, 2 * kk + 3);
                repeat (len) push_byte(base_char($urandom_range(0, 3)));
            end
            1: begin
                // Same k-1 bases at both ends, random bases between.
                repeat (ov) motif.push_back($urandom_range(0, 3));
                foreach (motif[i]) push_byte(base_char(motif[i]));
                repeat ($urandom_range(0, 6)) push_byte(base_char($urandom_range(0, 3)));
                foreach (motif[i]) push_byte(base_char(motif[i]));
                if (ov == 0) begin
                    push_byte(base_char($urandom_range(0, 3)));
                end
            end
            2: begin
                code = $urandom_range(0, 3);
                len  = $urandom_range(1, 2 * kk);
                repeat (len) push_byte(base_char(code));
            end
            default: begin
                // Lengths right around the overlap.
                len = (ov == 0) ? 1 : ov + $urandom_range(0, 1)
                                      - ((ov > 1) ? $urandom_range(0, 1) : 0);
                repeat (len) push_byte(base_char($urandom_range(0, 3)));
            end
        endcase
    endfunction

    // Mostly well-formed sequence text with random content, plus headers, noise and finishes.
    function automatic void push_slot(input int unsigned kk);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            push_header();
        end else if (r < 68) begin
            push_run(kk);
            push_byte(pick_break());
        end else if (r < 78) begin
            push_byte(CH_NEWLINE);
        end else if (r < 94) begin
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            push_finish();
        end
    endfunction

    // Waits until every queued item is taken and every expected result has arrived, then lets
    // the two-stage pipeline settle. Sampled at the falling edge to stay clear of the driver.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending.size() != 0 || drv_valid || tally_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic m, input logic [K_BITS-1:0] k);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MODE;
        cfg_data <= CFG_BITS'(m);
        @(posedge i_clk);
        cfg_idx  <= CFG_KMER;
        cfg_data <= k;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        p_mode = m;
        p_k    = k;
        n_settings++;
    endtask

    function automatic int unsigned pick_idle();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return 6;
            default: return 12;
        endcase
    endfunction

    // One setting of the registers and a stretch of random text under it. Some phases stop in
    // the middle until all results are back before sending the rest.
    task automatic run_phase(input logic m, input logic [K_BITS-1:0] k, input int unsigned n,
                             input int ending);
        int unsigned kk;
        int unsigned first;
        bit          paused;
        wait_idle();
        set_config(m, k);
        gap_max   = pick_idle();
        stall_max = pick_idle();
        kk        = k_in_use(k);
        first     = n_generated;
        paused    = ($urandom_range(0, 1) == 0);
        while (n_generated - first < n) begin
            if (!paused && n_generated - first >= n / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            push_slot(kk);
        end
        if (ending == END_OPEN) begin
            push_run(kk);
        end else if (ending == END_FINISH) begin
            push_finish();
        end
    endtask

    //------------------------------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset configuration (character mode, k of one), no idling on either side.
        // A header line is skipped, a '>' inside a line is plain text, every target character
        // in both cases counts, bytes at both ends of the range do not, and a finish reports.
        push_text(">A\n");
        push_text("aC>gT()");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_finish();

        // Directed, k-mer mode with k of three: a run closing as a cycle, a run exactly as long
        // as the overlap, and an open run flushed as a cycle by the finish.
        wait_idle();
        set_config(MODE_KMER, K_BITS'(3));
        push_text("ACGAC\n");
        push_text("AC$");
        push_text("GT");
        push_finish();

        // Random phases. Several leave a run open across a change of k or of mode; a finish in
        // character mode then drops the open run.
        run_phase(MODE_KMER,  K_BITS'(1),  70,  END_PLAIN);
        run_phase(MODE_KMER,  K_BITS'(2),  70,  END_OPEN);
        run_phase(MODE_CHARS, K_BITS'(2),  50,  END_OPEN);
        run_phase(MODE_KMER,  K_BITS'(3),  70,  END_OPEN);
        run_phase(MODE_KMER,  K_BITS'(32), 110, END_FINISH);
        run_phase(MODE_KMER,  K_BITS'(0),  60,  END_OPEN);
        run_phase(MODE_CHARS, K_BITS'(63), 50,  END_FINISH);
        run_phase(MODE_KMER,  K_BITS'(63), 80,  END_OPEN);
        run_phase(MODE_KMER,  K_BITS'(33), 70,  END_PLAIN);
        run_phase(MODE_KMER,  K_BITS'(5),  80,  END_OPEN);
        run_phase(MODE_KMER,  K_BITS'(16), 70,  END_PLAIN);
        run_phase(MODE_CHARS, K_BITS'(1),  40,  END_FINISH);

        wait_idle();
        if (tally_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, tally_q.size());
            n_errors += tally_q.size();
        end
        $display("Sent %0d items (%0d finish) under %0d register settings; checked %0d results.",
                 n_accepted, n_finishes, n_settings, n_checked);
        $display("Predicted %0d implicit cycles; %0d mismatches.", n_cycles_pred, n_errors);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
